// File: hdl/lei_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lei_pkg: shared constants, types and pointer helpers
// Sizes, key codes, read status codes and modulo-2*depth pointer arithmetic
// for the line editing input buffer.
// ----------------------------------------------------------------------------
package lei_pkg;

  // Buffer geometry
  localparam int BUFFER_DEPTH = 128;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int PTR_SPAN     = 2 * BUFFER_DEPTH;
  localparam int PTR_W        = $clog2(PTR_SPAN);
  localparam int DIFF_W       = PTR_W + 1;

  // Key codes
  localparam logic [7:0] KEY_NUL  = 8'h00;
  localparam logic [7:0] KEY_EOF  = 8'h04;
  localparam logic [7:0] KEY_BS   = 8'h08;
  localparam logic [7:0] KEY_LF   = 8'h0A;
  localparam logic [7:0] KEY_CR   = 8'h0D;
  localparam logic [7:0] KEY_KILL = 8'h15;
  localparam logic [7:0] KEY_DEL  = 8'h7F;

  // Command codes
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Read status codes
  localparam logic [2:0] RS_NONE  = 3'd0;
  localparam logic [2:0] RS_DATA  = 3'd1;
  localparam logic [2:0] RS_LINE  = 3'd2;
  localparam logic [2:0] RS_EOF   = 3'd3;
  localparam logic [2:0] RS_EMPTY = 3'd4;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // One result word
  typedef struct packed {
    logic [2:0] read_status;
    logic [7:0] read_byte;
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       line_committed;
  } result_t;

  // Store write request
  typedef struct packed {
    logic       we;
    addr_t      addr;
    logic [7:0] data;
  } mem_wr_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_inc = (p == ptr_t'(PTR_SPAN - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    ptr_dec = (p == '0) ? ptr_t'(PTR_SPAN - 1) : p - ptr_t'(1);
  endfunction

  // a - b modulo the pointer span
  function automatic ptr_t ptr_diff(input ptr_t a, input ptr_t b);
    logic [DIFF_W-1:0] wrap;
    wrap = DIFF_W'(a) + DIFF_W'(PTR_SPAN) - DIFF_W'(b);
    ptr_diff = (a >= b) ? a - b : wrap[PTR_W-1:0];
  endfunction

  // Store index: pointer modulo depth, pointer known below twice the depth
  function automatic addr_t ptr_slot(input ptr_t p);
    ptr_t s;
    s = (p >= ptr_t'(BUFFER_DEPTH)) ? p - ptr_t'(BUFFER_DEPTH) : p;
    ptr_slot = s[ADDR_W-1:0];
  endfunction

endpackage

// File: hdl/lei_char_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lei_char_ram: simple dual-port character store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lei_char_ram #(
  parameter int DEPTH  = 128,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/lei_ptr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lei_ptr_ctrl: read, commit and edit pointers and per-word decode
// Holds the three ring pointers, decodes one key or read word against the
// character fetched from the store and produces the result and store write.
// ----------------------------------------------------------------------------
module lei_ptr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  exec,
  input  logic                  command,
  input  logic [7:0]            key_code,
  input  logic                  read_first,
  input  logic [7:0]            rd_char,
  output lei_pkg::addr_t        rd_addr,
  output lei_pkg::mem_wr_t      mem_wr,
  output lei_pkg::result_t      result
);

  localparam int CNT_W = (lei_pkg::DIFF_W > 9) ? lei_pkg::DIFF_W : 9;

  lei_pkg::ptr_t read_ptr, commit_ptr, edit_ptr;
  lei_pkg::ptr_t read_ptr_next, commit_ptr_next, edit_ptr_next;
  lei_pkg::ptr_t fill, line_len, edit_inc;
  logic [CNT_W-1:0] kill_cnt;
  logic [7:0]       store_char;

  assign rd_addr  = lei_pkg::ptr_slot(read_ptr);
  assign fill     = lei_pkg::ptr_diff(edit_ptr, read_ptr);
  assign line_len = lei_pkg::ptr_diff(edit_ptr, commit_ptr);
  assign kill_cnt = CNT_W'(line_len);
  assign edit_inc = lei_pkg::ptr_inc(edit_ptr);
  assign store_char = (key_code == lei_pkg::KEY_CR) ? lei_pkg::KEY_LF : key_code;

  // Decode one word
  always_comb begin
    read_ptr_next   = read_ptr;
    commit_ptr_next = commit_ptr;
    edit_ptr_next   = edit_ptr;
    result          = '0;
    mem_wr.we       = 1'b0;
    mem_wr.addr     = lei_pkg::ptr_slot(edit_ptr);
    mem_wr.data     = store_char;

    if (command == lei_pkg::CMD_READ) begin
      if (read_ptr == commit_ptr) begin
        result.read_status = lei_pkg::RS_EMPTY;
      end else if (rd_char == lei_pkg::KEY_EOF) begin
        // end of file stays put unless it opens the request
        result.read_status = lei_pkg::RS_EOF;
        if (read_first) begin
          read_ptr_next = lei_pkg::ptr_inc(read_ptr);
        end
      end else begin
        read_ptr_next      = lei_pkg::ptr_inc(read_ptr);
        result.read_byte   = rd_char;
        result.read_status = (rd_char == lei_pkg::KEY_LF) ? lei_pkg::RS_LINE
                                                          : lei_pkg::RS_DATA;
      end
    end else if (key_code == lei_pkg::KEY_KILL) begin
      result.erase_count = (kill_cnt > CNT_W'(255)) ? 8'hFF : kill_cnt[7:0];
      edit_ptr_next      = commit_ptr;
    end else if (key_code == lei_pkg::KEY_BS || key_code == lei_pkg::KEY_DEL) begin
      if (edit_ptr != commit_ptr) begin
        edit_ptr_next      = lei_pkg::ptr_dec(edit_ptr);
        result.erase_count = 8'd1;
      end
    end else if (key_code != lei_pkg::KEY_NUL &&
                 fill < lei_pkg::ptr_t'(lei_pkg::BUFFER_DEPTH)) begin
      mem_wr.we         = 1'b1;
      edit_ptr_next     = edit_inc;
      result.echo_valid = 1'b1;
      result.echo_char  = store_char;
      // newline, end of file or a now-full buffer commits the line
      if (store_char == lei_pkg::KEY_LF || store_char == lei_pkg::KEY_EOF ||
          fill == lei_pkg::ptr_t'(lei_pkg::BUFFER_DEPTH - 1)) begin
        commit_ptr_next       = edit_inc;
        result.line_committed = 1'b1;
      end
    end

    if (!exec) begin
      mem_wr.we = 1'b0;
    end
  end

  // Pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr   <= '0;
      commit_ptr <= '0;
      edit_ptr   <= '0;
    end else if (exec) begin
      read_ptr   <= read_ptr_next;
      commit_ptr <= commit_ptr_next;
      edit_ptr   <= edit_ptr_next;
    end
  end

`ifndef SYNTHESIS
  // pointer ordering: read <= commit <= edit within one buffer
  a_order: assert property (@(posedge clk) disable iff (rst)
    lei_pkg::ptr_diff(commit_ptr, read_ptr) <= fill)
    else $error("commit pointer outside read..edit window");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    fill <= lei_pkg::ptr_t'(lei_pkg::BUFFER_DEPTH))
    else $error("buffer overfilled");

  a_span: assert property (@(posedge clk) disable iff (rst)
    edit_ptr < lei_pkg::ptr_t'(lei_pkg::PTR_SPAN - 1) ||
    edit_ptr == lei_pkg::ptr_t'(lei_pkg::PTR_SPAN - 1))
    else $error("edit pointer out of span");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !exec |=> $stable(read_ptr) && $stable(commit_ptr) && $stable(edit_ptr))
    else $error("pointer moved without a word in execution");

  a_wr_exec: assert property (@(posedge clk) disable iff (rst)
    mem_wr.we |-> exec && command == lei_pkg::CMD_KEY)
    else $error("store written outside key execution");
`endif

endmodule

// File: hdl/line_edit_input_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_input_buffer: canonical line editing input ring buffer
// Key words are edited into a ring store; read words take committed bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive command, key_code and read_first and raise start;
//   the word is taken at a clock edge with start high and busy low.
//   command 0 is a received key, command 1 reads one committed byte.
//   Result channel: every word gives exactly one result word, shown for one
//   cycle with done high; the receiver cannot stall it.
//   Timing: the accepting edge moves the sequencer to ST_EXEC and fetches the
//   character at the read pointer from the store into the registered read
//   data; the following cycle decodes the word, updates the pointers and
//   writes the store, and the edge that ends it registers the result and
//   raises done. The result is taken while done is high.
//   Busy is high while the sequencer is in ST_EXEC; no new word is taken
//   then, and the next word may be taken while done is shown.
//   Reset (rst, synchronous) clears the three pointers, the sequencer and
//   done; the store itself is not cleared and its data is used only once written.
// ----------------------------------------------------------------------------
module line_edit_input_buffer (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       command,
  input  logic [7:0] key_code,
  input  logic       read_first,
  output logic       done,
  output logic [2:0] read_status,
  output logic [7:0] read_byte,
  output logic       echo_valid,
  output logic [7:0] echo_char,
  output logic [7:0] erase_count,
  output logic       line_committed
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  logic       accept, exec;
  logic       cmd_q, first_q;
  logic [7:0] key_q;
  logic [7:0] rd_char;
  lei_pkg::addr_t   rd_addr;
  lei_pkg::mem_wr_t mem_wr;
  lei_pkg::result_t result, result_q;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign exec   = (state == ST_EXEC);

  // Sequencer
  always_comb begin
    case (state)
      ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= exec;
    end
  end

  // Input word capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= command;
      key_q   <= key_code;
      first_q <= read_first;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (exec) begin
      result_q <= result;
    end
  end

  assign read_status    = result_q.read_status;
  assign read_byte      = result_q.read_byte;
  assign echo_valid     = result_q.echo_valid;
  assign echo_char      = result_q.echo_char;
  assign erase_count    = result_q.erase_count;
  assign line_committed = result_q.line_committed;

  lei_char_ram #(
    .DEPTH  (lei_pkg::BUFFER_DEPTH),
    .WIDTH  (8),
    .ADDR_W (lei_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_wr.we),
    .waddr (mem_wr.addr),
    .wdata (mem_wr.data),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_char)
  );

  lei_ptr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .exec       (exec),
    .command    (cmd_q),
    .key_code   (key_q),
    .read_first (first_q),
    .rd_char    (rd_char),
    .rd_addr    (rd_addr),
    .mem_wr     (mem_wr),
    .result     (result)
  );

endmodule
